>>> design/r16_pkg.sv
// Package: shared types, constants and instruction helpers for the 16-bit executor.
`default_nettype none
package r16_pkg;
   localparam int unsigned MemWordsDefault = 8192;
   localparam int unsigned NumRegistersDefault = 8;

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_EXEC = 2'd1,
      CMD_RDMEM = 2'd2,
      CMD_RDREG = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      OP_REG = 3'd0,
      OP_ADDI = 3'd1,
      OP_J = 3'd2,
      OP_JAL = 3'd3,
      OP_LW = 3'd4,
      OP_SW = 3'd5,
      OP_JEQ = 3'd6,
      OP_SLTI = 3'd7
   } op_type;

   localparam logic [3:0] FN_ADD = 4'd0;
   localparam logic [3:0] FN_SUB = 4'd1;
   localparam logic [3:0] FN_OR = 4'd2;
   localparam logic [3:0] FN_AND = 4'd3;
   localparam logic [3:0] FN_SLT = 4'd4;
   localparam logic [3:0] FN_JR = 4'd8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DECODE,
      ST_MEM,
      ST_WRITE,
      ST_RESP,
      ST_CLEAR
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;     // latch request fields
      logic mem_rd_req;  // read memory at request address
      logic mem_rd_pc;   // fetch at pc
      logic latch_ins;   // capture fetched word and register operands
      logic mem_rd_ea;   // data read at effective address
      logic retire;      // commit instruction effects
      logic load_wr;     // store request word
      logic resp;        // drive result
      logic clear;       // zero one memory word of the clearing pass
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic halted;
      logic is_lw;
      logic clear_last;
   } sts_type;

   function automatic logic [15:0] sext7(input logic [15:0] ins);
      sext7 = {{9{ins[6]}}, ins[6:0]};
   endfunction

   // reduce a 13-bit word address modulo the memory size; words is at least 256,
   // so the quotient fits in five bits and five compare-subtract steps suffice
   function automatic logic [12:0] mem_index(input logic [12:0] a, input int unsigned words);
      logic [17:0] r;
      r = {5'd0, a};
      for (int k = 4; k >= 0; k--) begin
         if (r >= 18'(words << k)) r = r - 18'(words << k);
      end
      return r[12:0];
   endfunction
endpackage
`default_nettype wire

>>> design/r16_ctrl.sv
// Controller: runs each transaction through fetch and as needed decode, memory, write.
`default_nettype none
module r16_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire r16_pkg::sts_type sts,
   output r16_pkg::ctl_type ctl
);
   r16_pkg::state_type state_ff, state_in;

   // advance state; start with the memory clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= r16_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         r16_pkg::ST_CLEAR: begin
            if (sts.clear_last) state_in = r16_pkg::ST_IDLE;
         end
         r16_pkg::ST_IDLE: begin
            if (start) state_in = r16_pkg::ST_FETCH;
         end
         r16_pkg::ST_FETCH: begin
            if (sts.cmd == r16_pkg::CMD_EXEC && !sts.halted) state_in = r16_pkg::ST_DECODE;
            else state_in = r16_pkg::ST_RESP;
         end
         r16_pkg::ST_DECODE: state_in = r16_pkg::ST_MEM;
         r16_pkg::ST_MEM: state_in = sts.is_lw ? r16_pkg::ST_WRITE : r16_pkg::ST_RESP;
         r16_pkg::ST_WRITE: state_in = r16_pkg::ST_RESP;
         r16_pkg::ST_RESP: state_in = r16_pkg::ST_IDLE;
         default: state_in = r16_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl = '0;
      busy = (state_ff != r16_pkg::ST_IDLE);
      unique case (state_ff)
         r16_pkg::ST_CLEAR: ctl.clear = 1'b1;
         r16_pkg::ST_IDLE: begin
            ctl.capture = start;
         end
         r16_pkg::ST_FETCH: begin
            ctl.mem_rd_req = (sts.cmd == r16_pkg::CMD_RDMEM);
            ctl.mem_rd_pc = (sts.cmd == r16_pkg::CMD_EXEC) && !sts.halted;
            ctl.load_wr = (sts.cmd == r16_pkg::CMD_LOAD);
         end
         r16_pkg::ST_DECODE: ctl.latch_ins = 1'b1;
         r16_pkg::ST_MEM: begin
            ctl.mem_rd_ea = 1'b1;
            ctl.retire = !sts.is_lw;
         end
         r16_pkg::ST_WRITE: ctl.retire = 1'b1;
         r16_pkg::ST_RESP: ctl.resp = 1'b1;
         default: ctl = '0;
      endcase
   end

`ifndef ASSERT_OFF
   a_resp_one: assert property (@(posedge clock) disable iff (reset)
      ctl.resp |=> !ctl.resp) else $error("response held more than one cycle");
   a_no_capture_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !ctl.capture) else $error("capture while busy");
   a_retire_once: assert property (@(posedge clock) disable iff (reset)
      ctl.retire |=> !ctl.retire || state_ff == r16_pkg::ST_WRITE)
      else $error("retire repeated");
`endif
endmodule
`default_nettype wire

>>> design/r16_datapath.sv
// Datapath: register file, word memory, pc, halt flag and the instruction ALU.
`default_nettype none
module r16_datapath #(
   parameter int unsigned MEM_WORDS = r16_pkg::MemWordsDefault,
   parameter int unsigned NUM_REGISTERS = r16_pkg::NumRegistersDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic [1:0] req_cmd,
   input wire logic [12:0] req_address,
   input wire logic [15:0] req_write_data,
   input wire r16_pkg::ctl_type ctl,
   output r16_pkg::sts_type sts,
   output logic rsp_valid,
   output logic [15:0] rsp_program_counter,
   output logic rsp_halted,
   output logic [15:0] rsp_read_data
);
   localparam int unsigned AW = $clog2(MEM_WORDS);
   localparam int unsigned RW = $clog2(NUM_REGISTERS);

   logic [15:0] mem [MEM_WORDS];
   logic [15:0] regs_ff [NUM_REGISTERS];
   logic [15:0] pc_ff;
   logic halt_ff;
   r16_pkg::cmd_type cmd_ff;
   logic [12:0] addr_ff;
   logic [15:0] wdata_ff;
   logic [15:0] mdata_ff;
   logic [15:0] ins_ff, va_ff, vb_ff;
   logic [15:0] ea;
   logic [15:0] rdata_ff;
   logic [AW-1:0] clr_ff;
   logic [AW-1:0] idx_req, idx_pc, idx_ea;
   logic [AW-1:0] rd_idx;
   logic rd_en;
   logic [AW-1:0] wr_idx;
   logic [15:0] wr_data;
   logic wr_en;
   logic is_sw;

   assign ea = va_ff + r16_pkg::sext7(ins_ff);
   assign is_sw = (ins_ff[15:13] == r16_pkg::OP_SW);

   // word indexes, reduced to the memory size
   assign idx_req = AW'(r16_pkg::mem_index(addr_ff, MEM_WORDS));
   assign idx_pc = AW'(r16_pkg::mem_index(pc_ff[12:0], MEM_WORDS));
   assign idx_ea = AW'(r16_pkg::mem_index(ea[12:0], MEM_WORDS));

   always_comb begin
      rd_idx = idx_req;
      if (ctl.mem_rd_pc) rd_idx = idx_pc;
      if (ctl.mem_rd_ea) rd_idx = idx_ea;
      rd_en = ctl.mem_rd_req | ctl.mem_rd_pc | ctl.mem_rd_ea;
   end

   // select the single write: clearing pass, load command or sw
   always_comb begin
      wr_en = 1'b0;
      wr_idx = clr_ff;
      wr_data = '0;
      if (ctl.clear) begin
         wr_en = 1'b1;
      end else if (ctl.load_wr) begin
         wr_en = 1'b1;
         wr_idx = idx_req;
         wr_data = wdata_ff;
      end else if (ctl.retire && is_sw) begin
         wr_en = 1'b1;
         wr_idx = idx_ea;
         wr_data = vb_ff;
      end
   end

   // capture request
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff <= r16_pkg::cmd_type'(req_cmd);
         addr_ff <= req_address;
         wdata_ff <= req_write_data;
      end
   end

   // memory port: one read, one write
   always_ff @(posedge clock) begin
      if (rd_en) mdata_ff <= mem[rd_idx];
      if (wr_en) mem[wr_idx] <= wr_data;
   end

   // step through the memory once after reset, zeroing each word
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (ctl.clear) clr_ff <= clr_ff + AW'(1);
   end

   // decode: latch instruction and operands
   always_ff @(posedge clock) begin
      if (ctl.latch_ins) begin
         ins_ff <= mdata_ff;
         va_ff <= regs_ff[mdata_ff[12:10]];
         vb_ff <= regs_ff[mdata_ff[9:7]];
      end
   end

   // retire: register, pc and halt updates
   logic [15:0] mword, imm, nxt, wval, tgt;
   logic [RW-1:0] wreg;
   logic wen, pcen, jmp;
   always_comb begin
      mword = mdata_ff;
      imm = r16_pkg::sext7(ins_ff);
      nxt = pc_ff + 16'd1;
      wval = '0;
      wreg = ins_ff[9:7];
      wen = 1'b0;
      pcen = 1'b1;
      jmp = 1'b0;
      tgt = nxt;
      unique case (r16_pkg::op_type'(ins_ff[15:13]))
         r16_pkg::OP_REG: begin
            wreg = ins_ff[6:4];
            wen = 1'b1;
            unique case (ins_ff[3:0])
               r16_pkg::FN_ADD: wval = va_ff + vb_ff;
               r16_pkg::FN_SUB: wval = va_ff - vb_ff;
               r16_pkg::FN_OR: wval = va_ff | vb_ff;
               r16_pkg::FN_AND: wval = va_ff & vb_ff;
               r16_pkg::FN_SLT: wval = {15'd0, va_ff < vb_ff};
               r16_pkg::FN_JR: begin
                  wen = 1'b0;
                  jmp = 1'b1;
                  tgt = va_ff;
               end
               default: begin
                  wen = 1'b0;
                  pcen = 1'b0;
               end
            endcase
         end
         r16_pkg::OP_ADDI: begin
            wen = 1'b1;
            wval = va_ff + imm;
         end
         r16_pkg::OP_J: begin
            jmp = 1'b1;
            tgt = {3'd0, ins_ff[12:0]};
         end
         r16_pkg::OP_JAL: begin
            jmp = 1'b1;
            tgt = {3'd0, ins_ff[12:0]};
            wen = 1'b1;
            wreg = RW'(7);
            wval = nxt;
         end
         r16_pkg::OP_LW: begin
            wen = 1'b1;
            wval = mword;
         end
         r16_pkg::OP_SW: wen = 1'b0;
         r16_pkg::OP_JEQ: begin
            if (va_ff == vb_ff) begin
               jmp = 1'b1;
               tgt = nxt + imm;
            end
         end
         r16_pkg::OP_SLTI: begin
            wen = 1'b1;
            wval = {15'd0, va_ff < imm};
         end
         default: wen = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGISTERS; i++) regs_ff[i] <= '0;
         pc_ff <= '0;
         halt_ff <= 1'b0;
      end else if (ctl.retire) begin
         if (wen && wreg != '0) regs_ff[wreg] <= wval;
         if (pcen) pc_ff <= tgt;
         if (jmp && tgt == pc_ff) halt_ff <= 1'b1;
      end
   end

   // read data for register read
   always_ff @(posedge clock) begin
      if (ctl.capture) rdata_ff <= regs_ff[req_address[RW-1:0]];
   end

   assign sts.cmd = cmd_ff;
   assign sts.halted = halt_ff;
   assign sts.is_lw = (ins_ff[15:13] == r16_pkg::OP_LW);
   assign sts.clear_last = (clr_ff == AW'(MEM_WORDS - 1));

   assign rsp_valid = ctl.resp;
   assign rsp_program_counter = pc_ff;
   assign rsp_halted = halt_ff;
   always_comb begin
      unique case (cmd_ff)
         r16_pkg::CMD_RDMEM: rsp_read_data = mdata_ff;
         r16_pkg::CMD_RDREG: rsp_read_data = rdata_ff;
         default: rsp_read_data = '0;
      endcase
   end

`ifndef ASSERT_OFF
   a_r0_zero: assert property (@(posedge clock) disable iff (reset)
      regs_ff[0] == 16'd0) else $error("register zero written");
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff) else $error("halt flag cleared");
   a_halt_pc: assert property (@(posedge clock) disable iff (reset)
      $rose(halt_ff) |-> $stable(pc_ff)) else $error("halt without self jump");
`endif
endmodule
`default_nettype wire

>>> design/risc16_instruction_executor.sv
// Load, read and an execute while halted go from fetch straight to the response strobe;
// an execute adds decode and memory steps, lw a write step too; a new transaction can be taken once busy falls.
// One transaction at a time; busy stays high until the cycle after the strobe.
// Fetch and data access each use the read side of the single memory port.
// Reset: synchronous; clears pc, halt flag and registers, then a clearing pass zeroes
// each memory word with busy high. The receiver cannot stall; one strobe per result.
`default_nettype none
module risc16_instruction_executor #(
   parameter int unsigned MEM_WORDS = r16_pkg::MemWordsDefault,
   parameter int unsigned NUM_REGISTERS = r16_pkg::NumRegistersDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [1:0] req_cmd,
   input wire logic [12:0] req_address,
   input wire logic [15:0] req_write_data,
   output logic rsp_valid,
   output logic [15:0] rsp_program_counter,
   output logic rsp_halted,
   output logic [15:0] rsp_read_data
);
   r16_pkg::ctl_type ctl;
   r16_pkg::sts_type sts;

   r16_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
   );

   r16_datapath #(.MEM_WORDS(MEM_WORDS), .NUM_REGISTERS(NUM_REGISTERS)) u_dp (
      .clock(clock), .reset(reset),
      .req_cmd(req_cmd), .req_address(req_address), .req_write_data(req_write_data),
      .ctl(ctl), .sts(sts),
      .rsp_valid(rsp_valid), .rsp_program_counter(rsp_program_counter),
      .rsp_halted(rsp_halted), .rsp_read_data(rsp_read_data)
   );
endmodule
`default_nettype wire

>>> tb/tb_risc16_instruction_executor.sv
// Self-checking testbench for the 16-bit instruction executor: directed and random commands.
`default_nettype none
module tb_risc16_instruction_executor;
   localparam int NumWords = 8192;
   localparam int CycleLimit = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_cmd = '0;
   logic [12:0] req_address = '0;
   logic [15:0] req_write_data = '0;
   logic rsp_valid;
   logic [15:0] rsp_program_counter;
   logic rsp_halted;
   logic [15:0] rsp_read_data;

   typedef struct packed {
      logic [15:0] pc;
      logic halted;
      logic [15:0] rdata;
   } outcome_type;

   // predictor state
   logic [15:0] model_regs [8];
   logic [15:0] model_mem [NumWords];
   logic [15:0] model_pc;
   logic model_halt;

   outcome_type expected_outcomes[$];
   int error_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int cycle_count = 0;
   bit quiet_sender = 1'b0;

   risc16_instruction_executor dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_address(req_address), .req_write_data(req_write_data),
      .rsp_valid(rsp_valid), .rsp_program_counter(rsp_program_counter),
      .rsp_halted(rsp_halted), .rsp_read_data(rsp_read_data)
   );

   always #6 clock = ~clock;

   // bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [15:0] sign_ext7(input logic [15:0] w);
      return {{9{w[6]}}, w[6:0]};
   endfunction

   task automatic write_reg(input logic [2:0] r, input logic [15:0] v);
      if (r != 3'd0) model_regs[r] = v;
   endtask

   task automatic jump_to(input logic [15:0] t);
      if (t == model_pc) model_halt = 1'b1;
      model_pc = t;
   endtask

   // advance the processor model by one instruction
   task automatic execute_instruction();
      logic [15:0] ins, va, vb, imm, nxt, ea;
      r16_pkg::op_type op;
      logic [2:0] ra, rb, rd;
      logic [3:0] fn;
      ins = model_mem[model_pc[12:0]];
      op = r16_pkg::op_type'(ins[15:13]);
      ra = ins[12:10]; rb = ins[9:7]; rd = ins[6:4]; fn = ins[3:0];
      va = model_regs[ra]; vb = model_regs[rb];
      imm = sign_ext7(ins); nxt = model_pc + 16'd1;
      ea = va + imm;
      case (op)
         r16_pkg::OP_REG: begin
            if (fn == r16_pkg::FN_JR) jump_to(va);
            else if (fn == r16_pkg::FN_ADD || fn == r16_pkg::FN_SUB ||
                     fn == r16_pkg::FN_OR || fn == r16_pkg::FN_AND ||
                     fn == r16_pkg::FN_SLT) begin
               case (fn)
                  r16_pkg::FN_ADD: write_reg(rd, va + vb);
                  r16_pkg::FN_SUB: write_reg(rd, va - vb);
                  r16_pkg::FN_OR: write_reg(rd, va | vb);
                  r16_pkg::FN_AND: write_reg(rd, va & vb);
                  default: write_reg(rd, {15'd0, va < vb});
               endcase
               model_pc = nxt;
            end
         end
         r16_pkg::OP_ADDI: begin write_reg(rb, va + imm); model_pc = nxt; end
         r16_pkg::OP_J: jump_to({3'd0, ins[12:0]});
         r16_pkg::OP_JAL: begin write_reg(3'd7, nxt); jump_to({3'd0, ins[12:0]}); end
         r16_pkg::OP_LW: begin write_reg(rb, model_mem[ea[12:0]]); model_pc = nxt; end
         r16_pkg::OP_SW: begin model_mem[ea[12:0]] = vb; model_pc = nxt; end
         r16_pkg::OP_JEQ: begin
            if (va == vb) jump_to(nxt + imm);
            else model_pc = nxt;
         end
         default: begin write_reg(rb, {15'd0, va < imm}); model_pc = nxt; end
      endcase
   endtask

   task automatic predict_outcome(input r16_pkg::cmd_type c, input logic [12:0] a,
                                  input logic [15:0] d);
      outcome_type o;
      o.rdata = '0;
      case (c)
         r16_pkg::CMD_LOAD: model_mem[a] = d;
         r16_pkg::CMD_EXEC: if (!model_halt) execute_instruction();
         r16_pkg::CMD_RDMEM: o.rdata = model_mem[a];
         default: o.rdata = model_regs[a[2:0]];
      endcase
      o.pc = model_pc;
      o.halted = model_halt;
      expected_outcomes.push_back(o);
   endtask

   // send one transaction, with occasional idle gaps; start stays high until the next
   // call or the drain, so back to back calls need no gap
   task automatic issue_command(input r16_pkg::cmd_type c, input logic [12:0] a,
                                input logic [15:0] d);
      while (!quiet_sender && $urandom_range(99) < 9) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= c;
      req_address <= a;
      req_write_data <= d;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_outcome(c, a, d);
      sent_count++;
   endtask

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid) begin
         checked_count++;
         if (expected_outcomes.size() == 0) begin
            $display("%0t: unexpected result pc=%h halted=%b data=%h", $time,
                     rsp_program_counter, rsp_halted, rsp_read_data);
            error_count++;
         end else begin
            e = expected_outcomes.pop_front();
            if (rsp_program_counter !== e.pc) begin
               $display("%0t: pc expected %h actual %h", $time, e.pc, rsp_program_counter);
               error_count++;
            end
            if (rsp_halted !== e.halted) begin
               $display("%0t: halted expected %b actual %b", $time, e.halted, rsp_halted);
               error_count++;
            end
            if (rsp_read_data !== e.rdata) begin
               $display("%0t: read_data expected %h actual %h", $time, e.rdata,
                        rsp_read_data);
               error_count++;
            end
         end
      end
   end

   function automatic logic [15:0] encode_reg(input logic [2:0] ra, rb, rd,
                                              input logic [3:0] fn);
      return {r16_pkg::OP_REG, ra, rb, rd, fn};
   endfunction

   function automatic logic [15:0] encode_imm(input r16_pkg::op_type op,
                                              input logic [2:0] ra, rb,
                                              input logic [6:0] imm);
      return {op, ra, rb, imm};
   endfunction

   // random instruction with bias towards useful ones
   function automatic logic [15:0] random_instruction(input logic [15:0] at);
      logic [15:0] w;
      int pick;
      pick = $urandom_range(99);
      w = 16'($urandom);
      if (pick < 30) begin
         w = encode_reg(3'($urandom), 3'($urandom), 3'($urandom), 4'($urandom_range(4)));
      end else if (pick < 33) begin
         w[15:13] = r16_pkg::OP_REG;
      end else if (pick < 36) begin
         w = encode_reg(3'($urandom), 3'd0, 3'd0, r16_pkg::FN_JR);
      end else if (pick < 40) begin
         w = {r16_pkg::OP_J, 13'(at + $urandom_range(1, 3))};
      end else if (pick < 44) begin
         w = {r16_pkg::OP_JAL, 13'(at + $urandom_range(1, 3))};
      end else if (pick < 48) begin
         w = encode_imm(r16_pkg::OP_JEQ, 3'($urandom), 3'($urandom),
                        7'($urandom_range(0, 3)));
      end else if (pick < 50) begin
         w = {r16_pkg::OP_J, at[12:0]};
      end
      return w;
   endfunction

   task automatic reset_block();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (model_regs[i]) model_regs[i] = '0;
      foreach (model_mem[i]) model_mem[i] = '0;
      model_pc = '0;
      model_halt = 1'b0;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
   endtask

   // field extremes and plain reads and writes
   task automatic test_field_extremes();
      issue_command(r16_pkg::CMD_RDMEM, 13'h1FFF, 16'hFFFF);
      issue_command(r16_pkg::CMD_LOAD, 13'h1FFF, 16'hFFFF);
      issue_command(r16_pkg::CMD_LOAD, 13'h0AAA, 16'h5555);
      issue_command(r16_pkg::CMD_RDMEM, 13'h1FFF, 16'h0);
      issue_command(r16_pkg::CMD_RDMEM, 13'h0AAA, 16'h0);
      issue_command(r16_pkg::CMD_RDREG, 13'h1FF8, 16'h0);
      issue_command(r16_pkg::CMD_RDREG, 13'h1FFF, 16'hFFFF);
   endtask

   // most instructions once (no j, jal or jr), writes to r0, unknown function, unsigned slt
   task automatic test_each_instruction();
      logic [15:0] prog [15];
      prog[0] = encode_imm(r16_pkg::OP_ADDI, 3'd0, 3'd1, 7'h7F);   // r1 = -1
      prog[1] = encode_imm(r16_pkg::OP_ADDI, 3'd0, 3'd2, 7'h05);   // r2 = 5
      prog[2] = encode_reg(3'd1, 3'd2, 3'd3, r16_pkg::FN_ADD);
      prog[3] = encode_reg(3'd2, 3'd1, 3'd4, r16_pkg::FN_SUB);
      prog[4] = encode_reg(3'd1, 3'd2, 3'd5, r16_pkg::FN_OR);
      prog[5] = encode_reg(3'd1, 3'd2, 3'd6, r16_pkg::FN_AND);
      prog[6] = encode_reg(3'd2, 3'd1, 3'd7, r16_pkg::FN_SLT);    // unsigned: 5 < ffff
      prog[7] = encode_imm(r16_pkg::OP_SLTI, 3'd1, 3'd3, 7'h40);
      prog[8] = encode_imm(r16_pkg::OP_ADDI, 3'd1, 3'd0, 7'h3);   // r0 stays zero
      prog[9] = encode_imm(r16_pkg::OP_SW, 3'd2, 3'd1, 7'h7E);    // mem[3] = r1
      prog[10] = encode_imm(r16_pkg::OP_LW, 3'd0, 3'd4, 7'h03);
      prog[11] = encode_imm(r16_pkg::OP_JEQ, 3'd0, 3'd0, 7'h00);
      prog[12] = encode_reg(3'd1, 3'd2, 3'd3, 4'hF);              // unknown: holds pc
      for (int i = 0; i < 13; i++) issue_command(r16_pkg::CMD_LOAD, 13'(i), prog[i]);
      for (int i = 0; i < 14; i++) issue_command(r16_pkg::CMD_EXEC, 13'd0, 16'd0);
      for (int r = 0; r < 8; r++) issue_command(r16_pkg::CMD_RDREG, 13'(r), 16'd0);
   endtask

   // random programs run from a fresh pc; halts are reached often
   task automatic test_random_programs();
      int base;
      int len;
      logic [15:0] w;
      while (sent_count < 1180) begin
         // hold the sender busy without gaps over a long middle stretch
         quiet_sender = (sent_count >= 500 && sent_count < 800);
         base = int'(model_pc[12:0]);
         len = $urandom_range(4, 12);
         for (int i = 0; i < len; i++) begin
            w = random_instruction(16'(base + i));
            issue_command(r16_pkg::CMD_LOAD, 13'(base + i), w);
         end
         // a few data words near the start of memory for lw
         issue_command(r16_pkg::CMD_LOAD, 13'($urandom_range(0, 15)), 16'($urandom));
         if (model_halt) begin
            // halt cannot be cleared without reset; read state instead
            issue_command(r16_pkg::CMD_RDREG, 13'($urandom), 16'($urandom));
            issue_command(r16_pkg::CMD_RDMEM, 13'($urandom), 16'($urandom));
         end
         for (int i = 0; i < len; i++) begin
            issue_command(r16_pkg::CMD_EXEC, 13'($urandom), 16'($urandom));
         end
         if ($urandom_range(3) == 0) begin
            issue_command(r16_pkg::CMD_RDREG, 13'($urandom), 16'($urandom));
         end
         if ($urandom_range(3) == 0) begin
            issue_command(r16_pkg::CMD_RDMEM, 13'($urandom), 16'($urandom));
         end
      end
      quiet_sender = 1'b0;
   endtask

   initial begin
      reset_block();
      test_field_extremes();
      test_each_instruction();
      test_random_programs();
      drain_results();
      repeat (20) @(posedge clock);
      $display("Sent %0d transactions, checked %0d results.", sent_count, checked_count);
      $display("Covered loads, reads, all instructions, halts and random programs.");
      if (error_count == 0 && expected_outcomes.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> risc16_instruction_executor.f
design/r16_pkg.sv
design/r16_ctrl.sv
design/r16_datapath.sv
design/risc16_instruction_executor.sv
tb/tb_risc16_instruction_executor.sv
